// File: rtl/pnf_pkg.sv
// Shared types and constants for the fractal Perlin noise pipeline.
`timescale 1ns / 1ps

package pnf_pkg;

  // Amplitude in Q16, capped at 2^40.
  localparam int AmpW = 41;
  // Sum of up to sixteen capped amplitudes.
  localparam int MaxvW = 46;
  // Quotient bits: sixteen result bits plus one overflow bit.
  localparam int QW = 17;

  localparam logic [AmpW-1:0] AmpOne = AmpW'(65536);
  localparam logic [AmpW-1:0] AmpCap = {1'b1, 40'b0};

  // Item commands.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  // Configuration register indexes.
  localparam logic CfgOctaveCount = 1'b0;
  localparam logic CfgPersistence = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
  } in_payload_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
  } out_payload_t;

  // Item as it travels along the octave cells.
  typedef struct packed {
    logic               valid;
    logic               evl;
    logic [2:0][31:0]   coord;
    logic [7:0]         idx;
    logic [7:0]         val;
    logic signed [63:0] total;
    logic [MaxvW-1:0]   maxv;
    logic [AmpW-1:0]    amp;
  } item_t;

  // Item as it travels along the divider cells.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MaxvW:0]   den;
    logic [63:0]      rem;
    logic [QW-1:0]    quo;
  } div_item_t;

endpackage

// File: rtl/pnf_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
`timescale 1ns / 1ps

interface pnf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/pnf_octave_cell.sv
// One octave cell: hashes, fades, gradients, lerps and accumulates one octave.
`timescale 1ns / 1ps

module pnf_octave_cell #(
  parameter int OCT_INDEX       = 0,
  parameter int COORD_FRAC_BITS = 16,
  parameter int CNT_W           = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [CNT_W-1:0]    octaves,
  input  logic [15:0]         persistence,
  input  pnf_pkg::item_t      item_in,
  output pnf_pkg::item_t      item_out
);

  localparam int NumStages  = 12;
  localparam int PermCopies = 7;
  localparam int FracDn     = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
  localparam int FracUp     = (COORD_FRAC_BITS >= 16) ? 0 : 16 - COORD_FRAC_BITS;
  localparam logic [63:0] FracMask = (64'd1 << COORD_FRAC_BITS) - 64'd1;

  function automatic logic signed [19:0] grad(input logic [3:0] h,
                                               input logic signed [17:0] x,
                                               input logic signed [17:0] y,
                                               input logic signed [17:0] z);
    logic signed [17:0] u;
    logic signed [17:0] v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -20'(u) : 20'(u)) + (h[1] ? -20'(v) : 20'(v));
  endfunction

  function automatic logic signed [17:0] offs(input logic [15:0] f, input logic far);
    return far ? $signed(18'(f)) - 18'sd65536 : $signed(18'(f));
  endfunction

  pnf_pkg::item_t cr [1:NumStages];

  // Permutation table copies, one per read pair.
  logic [7:0] perm_mem [PermCopies][256];
  logic [7:0] ra [PermCopies][2];
  logic [7:0] rd [PermCopies][2];
  logic       we [PermCopies];
  logic [7:0] widx [PermCopies];
  logic [7:0] wval [PermCopies];

  // Stage 0
  logic [63:0] sc [3];
  logic [7:0]  cix [3];
  logic [15:0] fr0 [3];
  logic [31:0] sq [3];
  logic [19:0] fsub [3];
  logic [35:0] fq [3];

  // Stage 1..3
  logic [7:0]  cy1, cz1, cz2;
  logic [15:0] fr1 [3];
  logic [15:0] fr2 [3];
  logic [15:0] fr3 [3];
  logic [15:0] tt1 [3];
  logic [19:0] tq1 [3];
  logic [31:0] t3p [3];
  logic [15:0] t3_2 [3];
  logic [19:0] bq2 [3];
  logic [35:0] fp [3];
  logic [7:0]  ab, bb, hb [4];
  logic [16:0] fd [3:8][3];
  logic signed [19:0] g3 [8];

  // Stage 4..11
  logic signed [19:0] g4 [8];
  logic signed [19:0] dx [4];
  logic signed [37:0] px [4];
  logic signed [37:0] px5 [4];
  logic signed [19:0] ga5 [4];
  logic signed [19:0] lx [4];
  logic signed [19:0] l6 [4];
  logic signed [19:0] dl [2];
  logic signed [37:0] py [2];
  logic signed [37:0] py7 [2];
  logic signed [19:0] la7 [2];
  logic signed [19:0] my [2];
  logic signed [19:0] m8 [2];
  logic signed [19:0] dm;
  logic signed [37:0] pz, pz9;
  logic signed [19:0] m9, val, val10;
  logic signed [61:0] wp, wp11;
  logic [56:0]        ap;
  logic [42:0]        ash;
  logic [pnf_pkg::AmpW-1:0] ampn, an11;
  logic               active;
  pnf_pkg::item_t     upd;

  assign active = octaves > CNT_W'(OCT_INDEX);
  assign item_out = cr[NumStages];

  // Stage 0: split coordinates, first fade products, first hash level.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sc[j]   = {{32{item_in.coord[j][31]}}, item_in.coord[j]} << OCT_INDEX;
      cix[j]  = sc[j][COORD_FRAC_BITS +: 8];
      fr0[j]  = 16'(((sc[j] & FracMask) >> FracDn) << FracUp);
      sq[j]   = 32'(fr0[j]) * 32'(fr0[j]);
      fsub[j] = 20'd983040 - 20'(fr0[j]) * 20'd6;
      fq[j]   = 36'(fr0[j]) * 36'(fsub[j]);
    end
  end

  // Stage 1 and 2: remaining hash levels and fade products.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t3p[j] = 32'(tt1[j]) * 32'(fr1[j]);
      fp[j]  = 36'(t3_2[j]) * 36'(bq2[j]);
    end
    ab = rd[0][0] + cy1;
    bb = rd[0][1] + cy1;
    hb[0] = rd[1][0] + cz2;
    hb[1] = rd[1][1] + cz2;
    hb[2] = rd[2][0] + cz2;
    hb[3] = rd[2][1] + cz2;
  end

  // Table copy addressing: each copy is written by a load as it passes the
  // stage that reads the copy, so loads and evaluations stay in order.
  always_comb begin
    ra[0][0] = cix[0];
    ra[0][1] = cix[0] + 8'd1;
    ra[1][0] = ab;
    ra[1][1] = ab + 8'd1;
    ra[2][0] = bb;
    ra[2][1] = bb + 8'd1;
    for (int c = 3; c < PermCopies; c++) begin
      ra[c][0] = hb[c-3];
      ra[c][1] = hb[c-3] + 8'd1;
    end
    we[0]   = item_in.valid && !item_in.evl;
    widx[0] = item_in.idx;
    wval[0] = item_in.val;
    for (int c = 1; c < 3; c++) begin
      we[c]   = cr[1].valid && !cr[1].evl;
      widx[c] = cr[1].idx;
      wval[c] = cr[1].val;
    end
    for (int c = 3; c < PermCopies; c++) begin
      we[c]   = cr[2].valid && !cr[2].evl;
      widx[c] = cr[2].idx;
      wval[c] = cr[2].val;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < PermCopies; c++) begin
        if (we[c]) begin
          perm_mem[c][widx[c]] <= wval[c];
        end
        for (int p = 0; p < 2; p++) begin
          rd[c][p] <= perm_mem[c][ra[c][p]];
        end
      end
    end
  end

  // Stage 3: gradients at the eight corners. Copy 3 + 2*xside + yside holds
  // the corner hashes, port zside.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int s = 0; s < 2; s++) begin
        g3[2*k+s] = grad(rd[3 + 2*s + (k & 1)][k >> 1][3:0],
                         offs(fr3[0], s[0]),
                         offs(fr3[1], k[0]),
                         offs(fr3[2], k[1]));
      end
    end
  end

  // Stage 4..9: lerp along x, then y, then z.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dx[k] = g4[2*k+1] - g4[2*k];
      px[k] = 38'(dx[k]) * 38'($signed({1'b0, fd[4][0]}));
      lx[k] = ga5[k] + 20'(px5[k] >>> 16);
    end
    for (int j = 0; j < 2; j++) begin
      dl[j] = l6[2*j+1] - l6[2*j];
      py[j] = 38'(dl[j]) * 38'($signed({1'b0, fd[6][1]}));
      my[j] = la7[j] + 20'(py7[j] >>> 16);
    end
    dm  = m8[1] - m8[0];
    pz  = 38'(dm) * 38'($signed({1'b0, fd[8][2]}));
    val = m9 + 20'(pz9 >>> 16);
  end

  // Stage 10..11: weight, next amplitude, accumulate.
  always_comb begin
    wp   = 62'(val10) * 62'($signed({1'b0, cr[10].amp}));
    ap   = 57'(cr[10].amp) * 57'(persistence);
    ash  = ap[56:14];
    ampn = (ash > 43'(pnf_pkg::AmpCap)) ? pnf_pkg::AmpCap : ash[pnf_pkg::AmpW-1:0];
    upd  = cr[11];
    if (active && cr[11].evl) begin
      upd.total = cr[11].total + 64'(wp11);
      upd.maxv  = cr[11].maxv + pnf_pkg::MaxvW'(cr[11].amp);
      upd.amp   = an11;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NumStages; k++) begin
        cr[k].valid <= 1'b0;
      end
    end else if (advance) begin
      cr[1] <= item_in;
      for (int k = 2; k < NumStages; k++) begin
        cr[k] <= cr[k-1];
      end
      cr[NumStages] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cy1 <= cix[1];
      cz1 <= cix[2];
      cz2 <= cz1;
      for (int j = 0; j < 3; j++) begin
        fr1[j]  <= fr0[j];
        fr2[j]  <= fr1[j];
        fr3[j]  <= fr2[j];
        tt1[j]  <= sq[j][31:16];
        tq1[j]  <= fq[j][35:16];
        t3_2[j] <= t3p[j][31:16];
        bq2[j]  <= 20'd655360 - tq1[j];
        fd[3][j] <= fp[j][32:16];
        for (int s = 4; s <= 8; s++) begin
          fd[s][j] <= fd[s-1][j];
        end
      end
      for (int k = 0; k < 8; k++) begin
        g4[k] <= g3[k];
      end
      for (int k = 0; k < 4; k++) begin
        px5[k] <= px[k];
        ga5[k] <= g4[2*k];
        l6[k]  <= lx[k];
      end
      for (int j = 0; j < 2; j++) begin
        py7[j] <= py[j];
        la7[j] <= l6[2*j];
        m8[j]  <= my[j];
      end
      pz9   <= pz;
      m9    <= m8[0];
      val10 <= val;
      wp11  <= wp;
      an11  <= ampn;
    end
  end

endmodule

// File: rtl/pnf_div_cell.sv
// One restoring-division cell: settles a single quotient bit.
`timescale 1ns / 1ps

module pnf_div_cell #(
  parameter int QBIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  pnf_pkg::div_item_t  d_in,
  output pnf_pkg::div_item_t  d_out
);

  logic [63:0]        trial;
  logic               fits;
  pnf_pkg::div_item_t d_next;

  always_comb begin
    trial  = 64'(d_in.den) << QBIT;
    fits   = d_in.rem >= trial;
    d_next = d_in;
    if (fits) begin
      d_next.rem = d_in.rem - trial;
    end
    d_next.quo[QBIT] = fits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (advance) begin
      d_out <= d_next;
    end
  end

endmodule

// File: rtl/perlin_noise_3d_fbm.sv
// Top level of the fractal 3D Perlin noise pipeline.
`timescale 1ns / 1ps

// Improved 3D Perlin noise summed over octaves, one item per clock. Each
// transfer on item is either a table load (cmd low), which writes one byte of
// the 256-entry permutation table and gives no result, or an evaluation
// (cmd high), which gives exactly one noise_value on result, in order.
// Evaluate only after all 256 table entries have been loaded. The datapath
// is a row of MAX_OCTAVES octave cells, each twelve stages deep and holding
// seven copies of the permutation table, followed by a row of seventeen
// divider cells that normalize the weighted sum. Loads travel down the row
// and update each table copy as they pass, so loads and evaluations may be
// mixed freely. From transfer to result, an item passes the input register,
// the octave cells, the divider input register, the divider cells and the
// output register. Throughput is one item per cycle. The whole pipeline
// holds while a result waits and result.ready is low; item.ready then
// drops. Write configuration only when no item is in flight.
module perlin_noise_3d_fbm #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  pnf_stream_if.sink  item,
  pnf_stream_if.source result
);

  localparam int CntW = $clog2(MAX_OCTAVES + 1);

  // Configuration registers.
  logic [3:0]  octave_count;
  logic [15:0] persistence;
  logic [CntW-1:0] octaves;

  logic advance;
  logic out_valid;
  logic signed [15:0] noise;
  logic signed [15:0] noise_next;
  logic [pnf_pkg::QW-1:0] q;

  pnf_pkg::item_t     head;
  pnf_pkg::item_t     link [MAX_OCTAVES];
  pnf_pkg::div_item_t dv_head;
  pnf_pkg::div_item_t dq [pnf_pkg::QW];

  // Advance every stage whenever the output register is free or drains.
  assign advance    = !out_valid || result.ready;
  assign item.ready = advance;
  assign result.valid = out_valid;
  assign result.payload.noise_value = noise;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd1;
      persistence  <= 16'd8192;
    end else if (cfg_write) begin
      case (cfg_index)
        pnf_pkg::CfgOctaveCount: octave_count <= cfg_data[3:0];
        pnf_pkg::CfgPersistence: persistence <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero octaves acts as one; clamp at the cell count.
  always_comb begin
    if (octave_count == 4'd0) begin
      octaves = CntW'(1);
    end else if (32'(octave_count) > MAX_OCTAVES) begin
      octaves = CntW'(MAX_OCTAVES);
    end else begin
      octaves = CntW'(octave_count);
    end
  end

  // Capture each transfer and seed the running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (advance) begin
      head.valid    <= item.valid;
      head.evl      <= item.payload.cmd == pnf_pkg::CmdEval;
      head.coord[0] <= item.payload.coord_x;
      head.coord[1] <= item.payload.coord_y;
      head.coord[2] <= item.payload.coord_z;
      head.idx      <= item.payload.table_index;
      head.val      <= item.payload.table_value;
      head.total    <= 64'sd0;
      head.maxv     <= '0;
      head.amp      <= pnf_pkg::AmpOne;
    end
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    if (k == 0) begin : g_first
      pnf_octave_cell #(
        .OCT_INDEX(k), .COORD_FRAC_BITS(COORD_FRAC_BITS), .CNT_W(CntW)
      ) u_cell (
        .clk, .rst, .advance, .octaves, .persistence,
        .item_in(head), .item_out(link[k])
      );
    end else begin : g_rest
      pnf_octave_cell #(
        .OCT_INDEX(k), .COORD_FRAC_BITS(COORD_FRAC_BITS), .CNT_W(CntW)
      ) u_cell (
        .clk, .rst, .advance, .octaves, .persistence,
        .item_in(link[k-1]), .item_out(link[k])
      );
    end
  end

  // Drop loads here; take magnitude and sign of the weighted sum, divisor is
  // twice the sum of amplitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_head.valid <= 1'b0;
    end else if (advance) begin
      dv_head.valid <= link[MAX_OCTAVES-1].valid && link[MAX_OCTAVES-1].evl;
      dv_head.neg   <= link[MAX_OCTAVES-1].total < 0;
      dv_head.rem   <= (link[MAX_OCTAVES-1].total < 0) ?
                       64'(-link[MAX_OCTAVES-1].total) : 64'(link[MAX_OCTAVES-1].total);
      dv_head.den   <= {link[MAX_OCTAVES-1].maxv, 1'b0};
      dv_head.quo   <= '0;
    end
  end

  for (genvar k = 0; k < pnf_pkg::QW; k++) begin : g_div
    if (k == 0) begin : g_first
      pnf_div_cell #(.QBIT(pnf_pkg::QW - 1 - k)) u_div (
        .clk, .rst, .advance, .d_in(dv_head), .d_out(dq[k])
      );
    end else begin : g_rest
      pnf_div_cell #(.QBIT(pnf_pkg::QW - 1 - k)) u_div (
        .clk, .rst, .advance, .d_in(dq[k-1]), .d_out(dq[k])
      );
    end
  end

  // Saturate the truncated quotient to Q1.15.
  always_comb begin
    q = dq[pnf_pkg::QW-1].quo;
    if (dq[pnf_pkg::QW-1].neg) begin
      noise_next = (q > 17'd32768) ? -16'sd32768 : 16'(-q);
    end else begin
      noise_next = (q > 17'd32767) ? 16'sd32767 : 16'(q);
    end
  end

  // Output register: hold while the result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dq[pnf_pkg::QW-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      noise <= noise_next;
    end
  end

  // The divisor is at least twice the first amplitude.
  assert property (@(posedge clk) disable iff (rst)
    dv_head.valid |-> dv_head.den >= (pnf_pkg::MaxvW + 1)'(131072))
    else $error("divisor below twice the unit amplitude");

  // A stall freezes the pipeline.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(dq[pnf_pkg::QW-1].valid) && $stable(head.valid))
    else $error("pipeline moved during a stall");

endmodule
